>>> hw/rtl/mbw_pkg.sv
// Shared types and constants for the maze backtracker walk block.
// Holds the mode and direction codes, the cell and result records and the
// table of direction try orders. Depends on nothing.
`default_nettype none

package mbw_pkg;

  typedef enum logic [1:0] {MODE_START, MODE_STEP, MODE_READ, MODE_NONE} mode_t;

  typedef enum logic [1:0] {DIR_R, DIR_B, DIR_L, DIR_T} dir_t;

  localparam int unsigned NUM_PERMS = 24;

  typedef struct packed {
    logic       vis;
    logic [3:0] walls;
  } cell_t;

  localparam cell_t CELL_CLEAR = '{vis: 1'b0, walls: 4'hF};
  localparam cell_t CELL_START = '{vis: 1'b1, walls: 4'hF};

  typedef struct packed {
    logic [3:0] cur_row;
    logic [3:0] cur_col;
    logic [3:0] walls;
    logic       seen;
    logic       advanced;
    logic [1:0] direction;
    logic       done_res;
  } res_t;

  typedef struct packed {
    logic init;
    logic push;
    logic pop;
    logic rd;
  } stk_ctl_t;

  typedef struct packed {
    logic clear;
    logic wr;
    logic rd;
  } map_ctl_t;

  // Direction tried k-th sits in bits [2k+1:2k]; orders are lexicographic.
  function automatic logic [7:0] perm_dirs(input logic [4:0] order);
    logic [4:0] idx;
    logic [7:0] p;
    idx = (order >= 5'(NUM_PERMS)) ? order - 5'(NUM_PERMS) : order;
    unique case (idx)
      5'd0:  p = {DIR_T, DIR_L, DIR_B, DIR_R};
      5'd1:  p = {DIR_L, DIR_T, DIR_B, DIR_R};
      5'd2:  p = {DIR_T, DIR_B, DIR_L, DIR_R};
      5'd3:  p = {DIR_B, DIR_T, DIR_L, DIR_R};
      5'd4:  p = {DIR_L, DIR_B, DIR_T, DIR_R};
      5'd5:  p = {DIR_B, DIR_L, DIR_T, DIR_R};
      5'd6:  p = {DIR_T, DIR_L, DIR_R, DIR_B};
      5'd7:  p = {DIR_L, DIR_T, DIR_R, DIR_B};
      5'd8:  p = {DIR_T, DIR_R, DIR_L, DIR_B};
      5'd9:  p = {DIR_R, DIR_T, DIR_L, DIR_B};
      5'd10: p = {DIR_L, DIR_R, DIR_T, DIR_B};
      5'd11: p = {DIR_R, DIR_L, DIR_T, DIR_B};
      5'd12: p = {DIR_T, DIR_B, DIR_R, DIR_L};
      5'd13: p = {DIR_B, DIR_T, DIR_R, DIR_L};
      5'd14: p = {DIR_T, DIR_R, DIR_B, DIR_L};
      5'd15: p = {DIR_R, DIR_T, DIR_B, DIR_L};
      5'd16: p = {DIR_B, DIR_R, DIR_T, DIR_L};
      5'd17: p = {DIR_R, DIR_B, DIR_T, DIR_L};
      5'd18: p = {DIR_L, DIR_B, DIR_R, DIR_T};
      5'd19: p = {DIR_B, DIR_L, DIR_R, DIR_T};
      5'd20: p = {DIR_L, DIR_R, DIR_B, DIR_T};
      5'd21: p = {DIR_R, DIR_L, DIR_B, DIR_T};
      5'd22: p = {DIR_B, DIR_R, DIR_L, DIR_T};
      5'd23: p = {DIR_R, DIR_B, DIR_L, DIR_T};
      default: p = {DIR_T, DIR_L, DIR_B, DIR_R};
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mbw_if.sv
// Handshake channels of the maze backtracker walk block: command items in
// and result items out, each with valid, ready and payload. No dependencies.
`default_nettype none

interface mbw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [3:0] row;
  logic [3:0] col;
  logic [4:0] order;

  modport source (output valid, mode, row, col, order, input ready);
  modport sink (input valid, mode, row, col, order, output ready);
endinterface

interface mbw_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] cur_row;
  logic [3:0] cur_col;
  logic [3:0] walls;
  logic       seen;
  logic       advanced;
  logic [1:0] direction;
  logic       done_res;

  modport source (output valid, cur_row, cur_col, walls, seen, advanced, direction, done_res,
                  input ready);
  modport sink (input valid, cur_row, cur_col, walls, seen, advanced, direction, done_res,
                output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mbw_cell_mem.sv
// Cell memory: walls and visited mark of every grid cell, one read and one
// write port, registered read data, and a clearing sweep. Uses mbw_pkg.
`default_nettype none

module mbw_cell_mem
  import mbw_pkg::*;
#(
  parameter int unsigned AW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire map_ctl_t      ctl,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic [AW-1:0] wr_addr,
  input  wire cell_t         wr_data,
  output cell_t              rd_data,
  output logic               busy
);

  localparam int unsigned DEPTH = 2 ** AW;

  cell_t         mem [DEPTH];
  logic [AW-1:0] sweep;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b1;
      sweep <= '0;
    end else if (busy) begin
      if (sweep == '1) begin
        busy <= 1'b0;
      end
      sweep <= sweep + 1'b1;
    end else if (ctl.clear) begin
      busy  <= 1'b1;
      sweep <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[sweep] <= CELL_CLEAR;
    end else if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mbw_stack.sv
// Path stack: cell addresses of the current path in a memory, with the fill
// count and a registered read of the top entry. Uses mbw_pkg.
`default_nettype none

module mbw_stack
  import mbw_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned DW = 8,
  localparam int unsigned CNW = $clog2(DEPTH + 1),
  localparam int unsigned IW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire stk_ctl_t      ctl,
  input  wire logic [DW-1:0] wr_data,
  output logic [DW-1:0]      rd_data,
  output logic [CNW-1:0]     count
);

  logic [DW-1:0]  mem [DEPTH];
  logic [CNW-1:0] top_m1;
  logic [CNW-1:0] top_m2;
  logic           has_room;

  assign top_m1   = count - CNW'(1);
  assign top_m2   = count - CNW'(2);
  assign has_room = count < CNW'(DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.init) begin
      count <= CNW'(1);
    end else if (ctl.push && has_room) begin
      count <= count + 1'b1;
    end else if (ctl.pop && count != '0) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      mem[IW'(0)] <= wr_data;
    end else if (ctl.push && has_room) begin
      mem[count[IW-1:0]] <= wr_data;
    end
    if (ctl.rd) begin
      rd_data <= mem[ctl.pop ? top_m2[IW-1:0] : top_m1[IW-1:0]];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mbw_ctrl.sv
// Sequencer of the maze walk: takes command transactions, drives the cell
// memory and the path stack, and builds each result. Uses mbw_pkg and mbw_if.
`default_nettype none

module mbw_ctrl
  import mbw_pkg::*;
#(
  parameter int unsigned ROWS = 16,
  parameter int unsigned COLS = 16,
  parameter int unsigned RW = 4,
  parameter int unsigned CLW = 4,
  parameter int unsigned CNW = 9
) (
  input  wire logic                clk,
  input  wire logic                rst,
  mbw_in_if.sink                   item,
  input  wire logic                out_free,
  output logic                     res_valid,
  output res_t                     res,
  output map_ctl_t                 map_ctl,
  output logic [RW+CLW-1:0]        map_rd_addr,
  output logic [RW+CLW-1:0]        map_wr_addr,
  output cell_t                    map_wr_data,
  input  wire cell_t               map_rd_data,
  input  wire logic                clr_busy,
  output stk_ctl_t                 stk_ctl,
  output logic [RW+CLW-1:0]        stk_wr_data,
  input  wire logic [RW+CLW-1:0]   stk_rd_data,
  input  wire logic [CNW-1:0]      stk_count
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_RD, S_TOP, S_CUR, S_PROBE, S_CHECK, S_WCUR, S_BACK, S_BTOP, S_BMAP,
    S_EMIT
  } state_t;

  state_t         state;
  logic [RW-1:0]  cur_r, nb_r, st_r, cand_r, row_sat;
  logic [CLW-1:0] cur_c, nb_c, st_c, cand_c, col_sat;
  cell_t          cur_ent;
  logic [7:0]     dirs;
  logic [1:0]     k;
  dir_t           d, dsel, opp;
  logic           nb_ok, accept, row_in, col_in;
  logic [6:0]     row_w, col_w;

  function automatic logic [3:0] r4(input logic [RW-1:0] v);
    logic [6:0] w;
    w = 7'(v);
    return w[3:0];
  endfunction

  function automatic logic [3:0] c4(input logic [CLW-1:0] v);
    logic [6:0] w;
    w = 7'(v);
    return w[3:0];
  endfunction

  assign item.ready = (state == S_IDLE) && !clr_busy;
  assign accept     = item.valid && item.ready;
  assign res_valid  = (state == S_EMIT) && out_free;

  assign row_w   = 7'(item.row);
  assign col_w   = 7'(item.col);
  assign row_in  = row_w < 7'(ROWS);
  assign col_in  = col_w < 7'(COLS);
  assign row_sat = row_in ? row_w[RW-1:0] : RW'(ROWS - 1);
  assign col_sat = col_in ? col_w[CLW-1:0] : CLW'(COLS - 1);

  assign d   = dir_t'(dirs[{k, 1'b0} +: 2]);
  assign opp = dir_t'(dsel ^ 2'b10);

  always_comb begin
    cand_r = cur_r;
    cand_c = cur_c;
    nb_ok  = 1'b0;
    unique case (d)
      DIR_R: begin
        nb_ok  = cur_c != CLW'(COLS - 1);
        cand_c = cur_c + 1'b1;
      end
      DIR_B: begin
        nb_ok  = cur_r != RW'(ROWS - 1);
        cand_r = cur_r + 1'b1;
      end
      DIR_L: begin
        nb_ok  = cur_c != '0;
        cand_c = cur_c - 1'b1;
      end
      DIR_T: begin
        nb_ok  = cur_r != '0;
        cand_r = cur_r - 1'b1;
      end
    endcase
  end

  always_comb begin
    map_ctl     = '0;
    map_rd_addr = {cur_r, cur_c};
    map_wr_addr = {cur_r, cur_c};
    map_wr_data = cur_ent;
    stk_ctl     = '0;
    stk_wr_data = {nb_r, nb_c};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_t'(item.mode))
            MODE_START: map_ctl.clear = 1'b1;
            MODE_STEP:  stk_ctl.rd = stk_count != '0;
            MODE_READ: begin
              map_ctl.rd  = row_in && col_in;
              map_rd_addr = {row_w[RW-1:0], col_w[CLW-1:0]};
            end
            MODE_NONE: ;
          endcase
        end
      end
      S_CLR: begin
        if (!clr_busy) begin
          map_ctl.wr   = 1'b1;
          map_wr_addr  = {st_r, st_c};
          map_wr_data  = CELL_START;
          stk_ctl.init = 1'b1;
          stk_wr_data  = {st_r, st_c};
        end
      end
      S_TOP, S_BTOP: begin
        map_ctl.rd  = 1'b1;
        map_rd_addr = stk_rd_data;
      end
      S_PROBE: begin
        map_ctl.rd  = nb_ok;
        map_rd_addr = {cand_r, cand_c};
      end
      S_CHECK: begin
        map_ctl.wr  = !map_rd_data.vis;
        map_wr_addr = {nb_r, nb_c};
        map_wr_data = '{vis: 1'b1, walls: map_rd_data.walls & ~(4'b1 << opp)};
      end
      S_WCUR: begin
        map_ctl.wr   = 1'b1;
        map_wr_data  = '{vis: cur_ent.vis, walls: cur_ent.walls & ~(4'b1 << dsel)};
        stk_ctl.push = 1'b1;
      end
      S_BACK: begin
        stk_ctl.pop = 1'b1;
        stk_ctl.rd  = stk_count > CNW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            dirs <= perm_dirs(item.order);
            k    <= '0;
            st_r <= row_sat;
            st_c <= col_sat;
            res  <= '{cur_row: (mode_t'(item.mode) == MODE_READ) ? item.row : 4'd0,
                      cur_col: (mode_t'(item.mode) == MODE_READ) ? item.col : 4'd0,
                      walls: 4'd0, seen: 1'b0, advanced: 1'b0, direction: 2'b00,
                      done_res: stk_count == '0};
            unique case (mode_t'(item.mode))
              MODE_START: state <= S_CLR;
              MODE_STEP:  state <= (stk_count == '0) ? S_EMIT : S_TOP;
              MODE_READ:  state <= (row_in && col_in) ? S_RD : S_EMIT;
              MODE_NONE:  state <= S_EMIT;
            endcase
          end
        end
        S_CLR: begin
          if (!clr_busy) begin
            res   <= '{cur_row: r4(st_r), cur_col: c4(st_c), walls: CELL_START.walls,
                       seen: 1'b1, advanced: 1'b0, direction: 2'b00, done_res: 1'b0};
            state <= S_EMIT;
          end
        end
        S_RD: begin
          res   <= '{cur_row: res.cur_row, cur_col: res.cur_col, walls: map_rd_data.walls,
                     seen: map_rd_data.vis, advanced: 1'b0, direction: 2'b00,
                     done_res: res.done_res};
          state <= S_EMIT;
        end
        S_TOP: begin
          {cur_r, cur_c} <= stk_rd_data;
          state          <= S_CUR;
        end
        S_CUR: begin
          cur_ent <= map_rd_data;
          state   <= S_PROBE;
        end
        S_PROBE: begin
          if (nb_ok) begin
            nb_r  <= cand_r;
            nb_c  <= cand_c;
            dsel  <= d;
            state <= S_CHECK;
          end else if (k == 2'd3) begin
            state <= S_BACK;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_CHECK: begin
          if (map_rd_data.vis) begin
            if (k == 2'd3) begin
              state <= S_BACK;
            end else begin
              k     <= k + 1'b1;
              state <= S_PROBE;
            end
          end else begin
            res   <= '{cur_row: r4(nb_r), cur_col: c4(nb_c),
                       walls: map_rd_data.walls & ~(4'b1 << opp), seen: 1'b1,
                       advanced: 1'b1, direction: dsel, done_res: 1'b0};
            state <= S_WCUR;
          end
        end
        S_WCUR: state <= S_EMIT;
        S_BACK: begin
          if (stk_count == CNW'(1)) begin
            res   <= '{cur_row: 4'd0, cur_col: 4'd0, walls: 4'd0, seen: 1'b0,
                       advanced: 1'b0, direction: 2'b00, done_res: 1'b1};
            state <= S_EMIT;
          end else begin
            state <= S_BTOP;
          end
        end
        S_BTOP: begin
          {cur_r, cur_c} <= stk_rd_data;
          state          <= S_BMAP;
        end
        S_BMAP: begin
          res   <= '{cur_row: r4(cur_r), cur_col: c4(cur_c), walls: map_rd_data.walls,
                     seen: 1'b1, advanced: 1'b0, direction: 2'b00, done_res: 1'b0};
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/maze_backtracker_walk.sv
// Maze backtracker walk, top level: sequencer, cell memory, path stack and
// the result register. Uses mbw_pkg, mbw_if, mbw_cell_mem, mbw_stack, mbw_ctrl.
//
// Usage. Commands arrive as transactions on item (mode, row, col, order) and
// each gives exactly one result transaction on result. A start clears the
// grid, raises every wall and places the start cell on the path; a step
// moves the walk one cell forward, backtracks one cell or reports done;
// a read reports one cell. One command is worked on at a time.
// A start waits on the clearing sweep, one entry a cycle, through all
// R = 2**(clog2(ROWS) + clog2(COLS)) cell memory entries (256 by default).
// A step on an empty path reads no memory; otherwise its time is set by the
// single read port of the cell memory: each in-grid neighbour is probed with
// a read and then a check, a direction off the grid with no read, up to four
// per step. A read of a cell outside the grid reads no memory.
// After reset the cell memory is swept over all R entries; item.ready stays low
// meanwhile. A finished result sits in an output register: the next command
// is taken while it waits, and a further result waits inside until the
// receiver takes the one in front.
`default_nettype none

module maze_backtracker_walk
  import mbw_pkg::*;
#(
  parameter int unsigned ROWS = 16,
  parameter int unsigned COLS = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  mbw_in_if.sink    item,
  mbw_out_if.source result
);

  localparam int unsigned RW = $clog2(ROWS);
  localparam int unsigned CLW = $clog2(COLS);
  localparam int unsigned AW = RW + CLW;
  localparam int unsigned NCELLS = ROWS * COLS;
  localparam int unsigned CNW = $clog2(NCELLS + 1);

  map_ctl_t       map_ctl;
  logic [AW-1:0]  map_rd_addr, map_wr_addr;
  cell_t          map_wr_data, map_rd_data;
  logic           clr_busy;
  stk_ctl_t       stk_ctl;
  logic [AW-1:0]  stk_wr_data, stk_rd_data;
  logic [CNW-1:0] stk_count;
  logic           res_valid, out_free, out_valid;
  res_t           res, out_res;

  mbw_cell_mem #(.AW(AW)) u_cell_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (map_ctl),
    .rd_addr (map_rd_addr),
    .wr_addr (map_wr_addr),
    .wr_data (map_wr_data),
    .rd_data (map_rd_data),
    .busy    (clr_busy)
  );

  mbw_stack #(.DEPTH(NCELLS), .DW(AW)) u_stack (
    .clk     (clk),
    .rst     (rst),
    .ctl     (stk_ctl),
    .wr_data (stk_wr_data),
    .rd_data (stk_rd_data),
    .count   (stk_count)
  );

  mbw_ctrl #(.ROWS(ROWS), .COLS(COLS), .RW(RW), .CLW(CLW), .CNW(CNW)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .out_free    (out_free),
    .res_valid   (res_valid),
    .res         (res),
    .map_ctl     (map_ctl),
    .map_rd_addr (map_rd_addr),
    .map_wr_addr (map_wr_addr),
    .map_wr_data (map_wr_data),
    .map_rd_data (map_rd_data),
    .clr_busy    (clr_busy),
    .stk_ctl     (stk_ctl),
    .stk_wr_data (stk_wr_data),
    .stk_rd_data (stk_rd_data),
    .stk_count   (stk_count)
  );

  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign result.valid     = out_valid;
  assign result.cur_row   = out_res.cur_row;
  assign result.cur_col   = out_res.cur_col;
  assign result.walls     = out_res.walls;
  assign result.seen      = out_res.seen;
  assign result.advanced  = out_res.advanced;
  assign result.direction = out_res.direction;
  assign result.done_res  = out_res.done_res;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> out_free)
    else $error("A result was written over one still waiting to be taken.");

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !(item.valid && item.ready))
    else $error("A command was taken while the cell memory was being cleared.");

  a_advance_shape: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.advanced) |-> (res.seen && !res.done_res))
    else $error("An advancing step reported an unvisited cell or an empty path.");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stk_count <= CNW'(NCELLS))
    else $error("The path stack holds more entries than the grid has cells.");

endmodule

`default_nettype wire
